FILE: sv/bus_telegram_checker_defines.svh
// ----------------------------------------------------------------------------
// bus_telegram_checker_defines
// Assertion helpers shared by the telegram checker modules.
// ----------------------------------------------------------------------------
`ifndef BUS_TELEGRAM_CHECKER_DEFINES_SVH
`define BUS_TELEGRAM_CHECKER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BTC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: sv/btc_pkg.sv
// ----------------------------------------------------------------------------
// btc_pkg
// Types, status codes and byte-level helper functions of the telegram checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package btc_pkg;

   typedef struct packed {
      logic [7:0] wire_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind_of_telegram;
      logic [3:0] master_result;
      logic [3:0] slave_result;
      logic       telegram_ok;
      logic [7:0] source_out;
      logic [7:0] target_out;
      logic [7:0] primary_out;
      logic [7:0] secondary_out;
      logic [4:0] master_count_out;
      logic [4:0] slave_count_out;
      logic [7:0] master_ack_out;
      logic [7:0] slave_ack_out;
   } rsp_type;

   typedef enum logic [5:0] {
      PH_MHDR  = 6'b000001,
      PH_MDATA = 6'b000010,
      PH_MACK  = 6'b000100,
      PH_SNN   = 6'b001000,
      PH_SDATA = 6'b010000,
      PH_SACK  = 6'b100000
   } phase_type;

   localparam logic [3:0] RES_EMPTY       = 4'd0;
   localparam logic [3:0] RES_OK          = 4'd1;
   localparam logic [3:0] RES_TOO_SHORT   = 4'd2;
   localparam logic [3:0] RES_BAD_SOURCE  = 4'd3;
   localparam logic [3:0] RES_BAD_TARGET  = 4'd4;
   localparam logic [3:0] RES_BAD_LENGTH  = 4'd5;
   localparam logic [3:0] RES_CRC         = 4'd6;
   localparam logic [3:0] RES_ACK_MISSING = 4'd7;
   localparam logic [3:0] RES_ACK_INVALID = 4'd8;
   localparam logic [3:0] RES_NAK_TWICE   = 4'd9;

   localparam logic [1:0] KIND_UNDEFINED     = 2'd0;
   localparam logic [1:0] KIND_BROADCAST     = 2'd1;
   localparam logic [1:0] KIND_MASTER_MASTER = 2'd2;
   localparam logic [1:0] KIND_MASTER_SLAVE  = 2'd3;

   localparam logic [7:0] SYM_ESCAPE    = 8'hA9;
   localparam logic [7:0] SYM_SYN       = 8'hAA;
   localparam logic [7:0] SYM_ESC_SYN   = 8'h01;
   localparam logic [7:0] SYM_ESC_ESC   = 8'h00;
   localparam logic [7:0] SYM_ACK       = 8'h00;
   localparam logic [7:0] SYM_NAK       = 8'hFF;
   localparam logic [7:0] SYM_BROADCAST = 8'hFE;
   localparam logic [7:0] CRC_POLY      = 8'h9B;

   // One CRC-8 step: shift the register through eight bits, then add the byte.
   function automatic logic [7:0] crc_feed(input logic [7:0] c, input logic [7:0] b);
      logic [7:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
         r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
      end
      return r ^ b;
   endfunction

   // The CRC runs over the escaped form, so the two special symbols count twice.
   function automatic logic [7:0] crc_add(input logic [7:0] c, input logic [7:0] b);
      logic [7:0] r;
      if (b == SYM_ESCAPE) begin
         r = crc_feed(crc_feed(c, SYM_ESCAPE), SYM_ESC_ESC);
      end else if (b == SYM_SYN) begin
         r = crc_feed(crc_feed(c, SYM_ESCAPE), SYM_ESC_SYN);
      end else begin
         r = crc_feed(c, b);
      end
      return r;
   endfunction

   function automatic logic nib_master(input logic [3:0] n);
      return (n == 4'h0) || (n == 4'h1) || (n == 4'h3) || (n == 4'h7) || (n == 4'hF);
   endfunction

   function automatic logic is_master_addr(input logic [7:0] b);
      return nib_master(b[3:0]) && nib_master(b[7:4]);
   endfunction

   function automatic logic [1:0] kind_of(input logic [7:0] t);
      logic [1:0] k;
      if (t == SYM_BROADCAST) begin
         k = KIND_BROADCAST;
      end else if (is_master_addr(t)) begin
         k = KIND_MASTER_MASTER;
      end else begin
         k = KIND_MASTER_SLAVE;
      end
      return k;
   endfunction

   // A part's fields are reported only when the part got through its header.
   function automatic logic holds_part(input logic [3:0] code);
      return (code == RES_OK) || (code >= RES_CRC);
   endfunction

endpackage

FILE: sv/bus_telegram_checker.sv
// Flow: a request is registered on acceptance and parsed from there; the report
// for a telegram is registered in the result register when its last byte is parsed.
// Throughput: one request per cycle; only a last byte waits, and only while an
// earlier report still sits stalled in the result register.
// Reset: synchronous and active high; it empties both registers and puts the
// parser in its master header phase, to which every telegram's end also returns it.
// ----------------------------------------------------------------------------
// bus_telegram_checker
// Checks one captured bus telegram byte by byte and reports it on its last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bus_telegram_checker_defines.svh"

module bus_telegram_checker #(
   parameter int MAX_DATA_BYTES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  btc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output btc_pkg::rsp_type rsp_data
);

   // Input register: one request waits here while the parser works on it.
   logic             in_valid_ff, in_valid_in;
   btc_pkg::req_type in_data_ff;

   // The parser advances on every held request. A last byte also needs a free
   // result register, since it is the only request that makes a report.
   logic             advance;
   logic             report_valid;
   btc_pkg::rsp_type report;

   assign advance   = in_valid_ff &&
                      (!in_data_ff.last_byte || !rsp_valid || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!in_valid_ff || advance) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   // Un-escaping, header, CRC and ACK checks, all in a single pass per byte.
   btc_parser #(
      .MAX_DATA_BYTES(MAX_DATA_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .byte_in     (in_data_ff),
      .result_valid(report_valid),
      .result      (report)
   );

   // The report waits here so that the next telegram can start at once.
   btc_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (report_valid),
      .load_data(report),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   `BTC_ASSERT_NEXT(a_report_loaded, clock, reset, report_valid, rsp_valid)
   `BTC_ASSERT_SAME(a_stall_cause, clock, reset, req_stall,
                    in_valid_ff && in_data_ff.last_byte && rsp_valid && rsp_stall)
   `BTC_ASSERT_SAME(a_ok_means_master_ok, clock, reset, rsp_valid && rsp_data.telegram_ok,
                    rsp_data.master_result == btc_pkg::RES_OK)

endmodule

FILE: sv/btc_parser.sv
// ----------------------------------------------------------------------------
// btc_parser
// Byte-wise telegram parser: un-escaping, header, CRC and ACK checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bus_telegram_checker_defines.svh"

module btc_parser #(
   parameter int MAX_DATA_BYTES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  btc_pkg::req_type byte_in,
   output logic             result_valid,
   output btc_pkg::rsp_type result
);

   btc_pkg::phase_type phase_ff, phase_in;
   logic [4:0] pos_ff, pos_in;
   logic       esc_ff, esc_in;
   logic [7:0] crc_ff, crc_in;
   logic [4:0] mcount_ff, mcount_in;
   logic [4:0] scount_ff, scount_in;
   logic [3:0] mstat_ff, mstat_in;
   logic [3:0] sstat_ff, sstat_in;
   logic [1:0] type_ff, type_in;
   logic [7:0] hdr_ff [4];
   logic [7:0] hdr_in [4];
   logic [7:0] ack_ff [2];
   logic [7:0] ack_in [2];
   logic [1:0] retry_ff, retry_in;
   logic       fin_ff, fin_in;

   logic       take;
   logic [7:0] b;
   logic [3:0] ms, ss;
   logic       mv, sv;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      esc_in    = esc_ff;
      crc_in    = crc_ff;
      mcount_in = mcount_ff;
      scount_in = scount_ff;
      mstat_in  = mstat_ff;
      sstat_in  = sstat_ff;
      type_in   = type_ff;
      hdr_in    = hdr_ff;
      ack_in    = ack_ff;
      retry_in  = retry_ff;
      fin_in    = fin_ff;
      take      = 1'b0;
      b         = byte_in.wire_byte;

      if (esc_ff) begin
         esc_in = 1'b0;
         take   = !fin_ff;
         b      = (byte_in.wire_byte == btc_pkg::SYM_ESC_SYN) ?
                  btc_pkg::SYM_SYN : btc_pkg::SYM_ESCAPE;
      end else if (byte_in.wire_byte == btc_pkg::SYM_ESCAPE) begin
         esc_in = 1'b1;
      end else begin
         take = !fin_ff;
      end

      if (take) begin
         case (phase_ff)
            btc_pkg::PH_MHDR: begin
               if (pos_ff < 5'd4) begin
                  hdr_in[pos_ff[1:0]] = b;
               end
               crc_in = btc_pkg::crc_add(crc_ff, b);
               pos_in = pos_ff + 5'd1;
               if (pos_ff == 5'd4) begin
                  if (!btc_pkg::is_master_addr(hdr_in[0])) begin
                     mstat_in = btc_pkg::RES_BAD_SOURCE;
                     fin_in   = 1'b1;
                  end else if (hdr_in[1] == btc_pkg::SYM_ESCAPE ||
                               hdr_in[1] == btc_pkg::SYM_SYN) begin
                     mstat_in = btc_pkg::RES_BAD_TARGET;
                     fin_in   = 1'b1;
                  end else if (b > 8'(MAX_DATA_BYTES)) begin
                     mstat_in = btc_pkg::RES_BAD_LENGTH;
                     fin_in   = 1'b1;
                  end else begin
                     mcount_in = b[4:0];
                     pos_in    = 5'd0;
                     phase_in  = btc_pkg::PH_MDATA;
                  end
               end
            end
            btc_pkg::PH_MDATA: begin
               if (pos_ff < mcount_ff) begin
                  crc_in = btc_pkg::crc_add(crc_ff, b);
                  pos_in = pos_ff + 5'd1;
               end else begin
                  type_in = btc_pkg::kind_of(hdr_ff[1]);
                  if (b != crc_ff) begin
                     mstat_in = btc_pkg::RES_CRC;
                     fin_in   = 1'b1;
                  end else if (type_in == btc_pkg::KIND_BROADCAST) begin
                     mstat_in = retry_ff[0] ? btc_pkg::RES_NAK_TWICE : btc_pkg::RES_OK;
                     fin_in   = 1'b1;
                  end else begin
                     phase_in = btc_pkg::PH_MACK;
                  end
               end
            end
            btc_pkg::PH_MACK: begin
               ack_in[0] = b;
               if (b != btc_pkg::SYM_ACK && b != btc_pkg::SYM_NAK) begin
                  mstat_in = btc_pkg::RES_ACK_INVALID;
                  fin_in   = 1'b1;
               end else if (b == btc_pkg::SYM_NAK) begin
                  if (retry_ff[0]) begin
                     mstat_in = btc_pkg::RES_NAK_TWICE;
                     fin_in   = 1'b1;
                  end else begin
                     retry_in[0] = 1'b1;
                     phase_in    = btc_pkg::PH_MHDR;
                     pos_in      = 5'd0;
                     crc_in      = 8'd0;
                  end
               end else begin
                  mstat_in = btc_pkg::RES_OK;
                  if (type_ff == btc_pkg::KIND_MASTER_SLAVE) begin
                     phase_in = btc_pkg::PH_SNN;
                     crc_in   = 8'd0;
                  end else begin
                     fin_in = 1'b1;
                  end
               end
            end
            btc_pkg::PH_SNN: begin
               crc_in = btc_pkg::crc_add(crc_ff, b);
               if (b > 8'(MAX_DATA_BYTES)) begin
                  sstat_in = btc_pkg::RES_BAD_LENGTH;
                  fin_in   = 1'b1;
               end else begin
                  scount_in = b[4:0];
                  pos_in    = 5'd0;
                  phase_in  = btc_pkg::PH_SDATA;
               end
            end
            btc_pkg::PH_SDATA: begin
               if (pos_ff < scount_ff) begin
                  crc_in = btc_pkg::crc_add(crc_ff, b);
                  pos_in = pos_ff + 5'd1;
               end else if (b != crc_ff) begin
                  sstat_in = btc_pkg::RES_CRC;
                  fin_in   = 1'b1;
               end else begin
                  phase_in = btc_pkg::PH_SACK;
               end
            end
            btc_pkg::PH_SACK: begin
               ack_in[1] = b;
               if (b != btc_pkg::SYM_ACK && b != btc_pkg::SYM_NAK) begin
                  sstat_in = btc_pkg::RES_ACK_INVALID;
                  fin_in   = 1'b1;
               end else if (b == btc_pkg::SYM_NAK) begin
                  if (retry_ff[1]) begin
                     sstat_in = btc_pkg::RES_NAK_TWICE;
                     fin_in   = 1'b1;
                  end else begin
                     retry_in[1] = 1'b1;
                     phase_in    = btc_pkg::PH_SNN;
                     crc_in      = 8'd0;
                  end
               end else begin
                  sstat_in = btc_pkg::RES_OK;
                  fin_in   = 1'b1;
               end
            end
            default: begin
               phase_in = btc_pkg::PH_MHDR;
            end
         endcase
      end
   end

   // An unfinished telegram is judged by the phase it stopped in.
   always_comb begin
      ms = mstat_in;
      ss = sstat_in;
      if (!fin_in) begin
         if (phase_in == btc_pkg::PH_MHDR || phase_in == btc_pkg::PH_MDATA) begin
            ms = btc_pkg::RES_TOO_SHORT;
         end else if (phase_in == btc_pkg::PH_MACK) begin
            ms = btc_pkg::RES_ACK_MISSING;
         end else if (phase_in == btc_pkg::PH_SNN || phase_in == btc_pkg::PH_SDATA) begin
            ss = btc_pkg::RES_TOO_SHORT;
         end else begin
            ss = btc_pkg::RES_ACK_MISSING;
         end
      end
      mv = btc_pkg::holds_part(ms);
      sv = btc_pkg::holds_part(ss);

      result.kind_of_telegram = type_in;
      result.master_result    = ms;
      result.slave_result     = ss;
      result.telegram_ok      = (type_in == btc_pkg::KIND_MASTER_SLAVE) ?
                                (ms == btc_pkg::RES_OK && ss == btc_pkg::RES_OK) :
                                (ms == btc_pkg::RES_OK);
      result.source_out       = mv ? hdr_in[0] : 8'd0;
      result.target_out       = mv ? hdr_in[1] : 8'd0;
      result.primary_out      = mv ? hdr_in[2] : 8'd0;
      result.secondary_out    = mv ? hdr_in[3] : 8'd0;
      result.master_count_out = mv ? mcount_in : 5'd0;
      result.slave_count_out  = sv ? scount_in : 5'd0;
      result.master_ack_out   = ack_in[0];
      result.slave_ack_out    = ack_in[1];
   end

   assign result_valid = step && byte_in.last_byte;

   // The last byte of a telegram returns the parser to its reset state.
   always_ff @(posedge clock) begin
      if (reset || result_valid) begin
         phase_ff  <= btc_pkg::PH_MHDR;
         pos_ff    <= 5'd0;
         esc_ff    <= 1'b0;
         crc_ff    <= 8'd0;
         mcount_ff <= 5'd0;
         scount_ff <= 5'd0;
         mstat_ff  <= btc_pkg::RES_EMPTY;
         sstat_ff  <= btc_pkg::RES_EMPTY;
         type_ff   <= btc_pkg::KIND_UNDEFINED;
         hdr_ff    <= '{default: 8'd0};
         ack_ff    <= '{default: 8'd0};
         retry_ff  <= 2'b00;
         fin_ff    <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         esc_ff    <= esc_in;
         crc_ff    <= crc_in;
         mcount_ff <= mcount_in;
         scount_ff <= scount_in;
         mstat_ff  <= mstat_in;
         sstat_ff  <= sstat_in;
         type_ff   <= type_in;
         hdr_ff    <= hdr_in;
         ack_ff    <= ack_in;
         retry_ff  <= retry_in;
         fin_ff    <= fin_in;
      end
   end

   `BTC_ASSERT_NEXT(a_end_clears, clock, reset, result_valid,
                    phase_ff == btc_pkg::PH_MHDR && !fin_ff && !esc_ff)
   `BTC_ASSERT_NEXT(a_latched_error, clock, reset, fin_ff && step && !byte_in.last_byte,
                    $stable(mstat_ff) && $stable(sstat_ff) && fin_ff)
   `BTC_ASSERT_SAME(a_count_limit, clock, reset, 1'b1,
                    mcount_ff <= 5'(MAX_DATA_BYTES) && scount_ff <= 5'(MAX_DATA_BYTES))

endmodule

FILE: sv/btc_rsp_reg.sv
// ----------------------------------------------------------------------------
// btc_rsp_reg
// Result register that holds a finished telegram report until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btc_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  btc_pkg::rsp_type load_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output btc_pkg::rsp_type rsp_data
);

   logic             valid_ff, valid_in;
   btc_pkg::rsp_type data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
